@@ rtl/core/bezier_node_tangent_calc_macros.svh @@
// ----------------------------------------------------------------------------
// Bezier node tangent calculator: assertion macros
// Shorthand for the concurrent checks used in the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef BEZIER_NODE_TANGENT_CALC_MACROS_SVH
`define BEZIER_NODE_TANGENT_CALC_MACROS_SVH

// Check that is switched off while reset is held.
`define BNTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check that also holds across reset.
`define BNTC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ rtl/core/bntc_pkg.sv @@
// ----------------------------------------------------------------------------
// Bezier node tangent calculator: package
// Widths, constants and the structures passed between the pipeline parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bntc_pkg;

  localparam int LVL_W  = 32;              // Q16.16 level
  localparam int GAP_W  = 32;              // frame gap
  localparam int POS_W  = 31;              // gap over three
  localparam int DIFF_W = GAP_W + 1;       // level difference, signed
  localparam int SUM_W  = LVL_W + 1;       // sum of two magnitudes
  localparam int PROD_W = 2 * GAP_W;       // 32 x 32 product
  localparam int FAC_W  = GAP_W + 18;      // 65536 * (L + R) + a + b
  localparam int WIDE_W = PROD_W + FAC_W;  // first wide product
  localparam int NUM_W  = WIDE_W + POS_W;  // dividend
  localparam int DEN_W  = WIDE_W;          // divisor
  localparam int Q_W    = 33;              // quotient bits before saturation

  localparam int M1_LANES = 4;
  localparam int M2_LANES = 2;

  // x / 3 == (x * RECIP3) >> RECIP3_SHIFT for every 32-bit x
  localparam logic [GAP_W-1:0] RECIP3       = 32'hAAAA_AAAB;
  localparam int               RECIP3_SHIFT = 33;
  localparam logic [1:0]       THIRD_DIV    = 2'd3;

  typedef enum logic [1:0] {
    MODE_SMOOTH = 2'd0,
    MODE_LINEAR = 2'd1,
    MODE_TIED   = 2'd2,
    MODE_FREE   = 2'd3
  } mode_t;

  // What one side of the node does with its control level.
  typedef struct packed {
    logic             bypass;  // take value instead of the quotient
    logic [LVL_W-1:0] value;
    logic             neg;     // sign applied to the quotient
  } side_t;

  typedef struct packed {
    mode_t            kind;
    logic [POS_W-1:0] pi;
    logic [POS_W-1:0] po;
    logic             ci_neg;
    logic             co_neg;
    logic [GAP_W-1:0] lin_in;
    logic [GAP_W-1:0] lin_out;
    side_t            side_in;
    side_t            side_out;
  } front_t;

  typedef struct packed {
    logic [POS_W-1:0] pi;
    logic [POS_W-1:0] po;
    side_t            side_in;
    side_t            side_out;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W-1:0] den_out;
  } mid_t;

  typedef struct packed {
    logic [POS_W-1:0] pi;
    logic [POS_W-1:0] po;
    side_t            side_in;
    side_t            side_out;
  } back_t;

endpackage

@@ rtl/core/bntc_prep.sv @@
// ----------------------------------------------------------------------------
// Bezier node tangent calculator: front end
// Three stages: differences and gap thirds, magnitudes and mode decisions,
// then the 32 x 32 products that feed the first wide multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bntc_prep (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             en,
  input  logic                                             in_valid,
  input  bntc_pkg::mode_t                                  mode,
  input  logic                                             has_prev,
  input  logic                                             has_next,
  input  logic [bntc_pkg::GAP_W-1:0]                       left_gap,
  input  logic [bntc_pkg::GAP_W-1:0]                       right_gap,
  input  logic [bntc_pkg::LVL_W-1:0]                       prev_level,
  input  logic [bntc_pkg::LVL_W-1:0]                       node_level,
  input  logic [bntc_pkg::LVL_W-1:0]                       next_level,
  input  logic [bntc_pkg::LVL_W-1:0]                       in_ctrl_level_now,
  input  logic [bntc_pkg::LVL_W-1:0]                       out_ctrl_level_now,
  output logic                                             out_valid,
  output logic [bntc_pkg::M1_LANES-1:0][bntc_pkg::PROD_W-1:0] lane_a,
  output logic [bntc_pkg::M1_LANES-1:0][bntc_pkg::FAC_W-1:0]  lane_b,
  output bntc_pkg::front_t                                 front
);

  // ---- stage 1 ----
  logic                          v1;
  bntc_pkg::mode_t               mode1;
  logic                          hp1, hn1;
  logic [bntc_pkg::GAP_W-1:0]    gl1, gr1;
  logic [bntc_pkg::DIFF_W-1:0]   dl1, dr1;
  logic [bntc_pkg::LVL_W-1:0]    ci1, co1;
  logic [bntc_pkg::PROD_W-1:0]   lk1, rk1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1 <= mode;
      hp1   <= has_prev;
      hn1   <= has_next;
      gl1   <= left_gap;
      gr1   <= right_gap;
      dl1   <= {node_level[bntc_pkg::LVL_W-1], node_level}
             - {prev_level[bntc_pkg::LVL_W-1], prev_level};
      dr1   <= {next_level[bntc_pkg::LVL_W-1], next_level}
             - {node_level[bntc_pkg::LVL_W-1], node_level};
      ci1   <= in_ctrl_level_now;
      co1   <= out_ctrl_level_now;
      lk1   <= left_gap * bntc_pkg::RECIP3;
      rk1   <= right_gap * bntc_pkg::RECIP3;
    end
  end

  // ---- stage 2 ----
  logic [bntc_pkg::DIFF_W-1:0]   dl_abs, dr_abs;
  logic [bntc_pkg::GAP_W-1:0]    a_c, b_c;
  logic [bntc_pkg::LVL_W-1:0]    ai_c, ao_c;
  logic [bntc_pkg::POS_W-1:0]    pi_c, po_c;
  logic [bntc_pkg::SUM_W-1:0]    s_c;
  logic [bntc_pkg::FAC_W-1:0]    f1_c, gfl_c, gfr_c;
  logic                          smooth_ok;
  bntc_pkg::side_t               side_in_c, side_out_c;

  always_comb begin
    dl_abs = dl1[bntc_pkg::DIFF_W-1] ? (bntc_pkg::DIFF_W'(0) - dl1) : dl1;
    dr_abs = dr1[bntc_pkg::DIFF_W-1] ? (bntc_pkg::DIFF_W'(0) - dr1) : dr1;
    a_c    = dl_abs[bntc_pkg::GAP_W-1:0];
    b_c    = dr_abs[bntc_pkg::GAP_W-1:0];
    ai_c   = ci1[bntc_pkg::LVL_W-1] ? (bntc_pkg::LVL_W'(0) - ci1) : ci1;
    ao_c   = co1[bntc_pkg::LVL_W-1] ? (bntc_pkg::LVL_W'(0) - co1) : co1;
    pi_c   = hp1 ? lk1[bntc_pkg::PROD_W-1:bntc_pkg::RECIP3_SHIFT] : '0;
    po_c   = hn1 ? rk1[bntc_pkg::PROD_W-1:bntc_pkg::RECIP3_SHIFT] : '0;
    s_c    = {1'b0, ai_c} + {1'b0, ao_c};
    f1_c   = bntc_pkg::FAC_W'({({1'b0, gl1} + {1'b0, gr1}), 16'h0000})
           + bntc_pkg::FAC_W'(a_c) + bntc_pkg::FAC_W'(b_c);
    gfl_c  = bntc_pkg::FAC_W'({gl1, 16'h0000}) + bntc_pkg::FAC_W'(a_c);
    gfr_c  = bntc_pkg::FAC_W'({gr1, 16'h0000}) + bntc_pkg::FAC_W'(b_c);

    smooth_ok = hp1 && hn1 && (gl1 != '0) && (gr1 != '0) && (dl1 != '0) &&
                (dr1 != '0) && (dl1[bntc_pkg::DIFF_W-1] == dr1[bntc_pkg::DIFF_W-1]);

    side_in_c  = '{bypass: 1'b1, value: ci1, neg: 1'b0};
    side_out_c = '{bypass: 1'b1, value: co1, neg: 1'b0};

    unique case (mode1)
      bntc_pkg::MODE_SMOOTH: begin
        side_in_c  = '{bypass: !smooth_ok, value: '0, neg: !dl1[bntc_pkg::DIFF_W-1]};
        side_out_c = '{bypass: !smooth_ok, value: '0, neg: dl1[bntc_pkg::DIFF_W-1]};
      end
      bntc_pkg::MODE_LINEAR: begin
        // prev - node is minus the left difference
        if (hp1) begin
          side_in_c = '{bypass: (gl1 == '0), value: '0, neg: !dl1[bntc_pkg::DIFF_W-1]};
        end
        if (hn1) begin
          side_out_c = '{bypass: (gr1 == '0), value: '0, neg: dr1[bntc_pkg::DIFF_W-1]};
        end
      end
      bntc_pkg::MODE_TIED: begin
        if ((pi_c != '0) && (po_c != '0)) begin
          if ((ai_c == '0) && (ao_c == '0)) begin
            side_in_c  = '{bypass: 1'b1, value: '0, neg: 1'b0};
            side_out_c = '{bypass: 1'b1, value: '0, neg: 1'b0};
          end else begin
            side_in_c  = '{bypass: 1'b0, value: '0, neg: 1'b0};
            side_out_c = '{bypass: 1'b0, value: '0, neg: 1'b0};
          end
        end
      end
      bntc_pkg::MODE_FREE: begin
        side_in_c  = '{bypass: 1'b1, value: ci1, neg: 1'b0};
        side_out_c = '{bypass: 1'b1, value: co1, neg: 1'b0};
      end
      default: begin
        side_in_c  = '{bypass: 1'b1, value: ci1, neg: 1'b0};
        side_out_c = '{bypass: 1'b1, value: co1, neg: 1'b0};
      end
    endcase
  end

  logic                          v2;
  bntc_pkg::mode_t               mode2;
  logic [bntc_pkg::POS_W-1:0]    pi2, po2;
  logic [bntc_pkg::GAP_W-1:0]    a2, b2, gl2, gr2;
  logic [bntc_pkg::LVL_W-1:0]    ai2, ao2;
  logic [bntc_pkg::SUM_W-1:0]    s2;
  logic [bntc_pkg::FAC_W-1:0]    f12, gfl2, gfr2;
  logic                          ci_neg2, co_neg2;
  bntc_pkg::side_t               side_in2, side_out2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode2     <= mode1;
      pi2       <= pi_c;
      po2       <= po_c;
      a2        <= a_c;
      b2        <= b_c;
      gl2       <= gl1;
      gr2       <= gr1;
      ai2       <= ai_c;
      ao2       <= ao_c;
      s2        <= s_c;
      f12       <= f1_c;
      gfl2      <= gfl_c;
      gfr2      <= gfr_c;
      ci_neg2   <= ci1[bntc_pkg::LVL_W-1];
      co_neg2   <= co1[bntc_pkg::LVL_W-1];
      side_in2  <= side_in_c;
      side_out2 <= side_out_c;
    end
  end

  // ---- stage 3 ----
  logic                        smooth2;
  logic [bntc_pkg::GAP_W-1:0]  m0x, m0y, m1x;

  always_comb begin
    smooth2 = (mode2 == bntc_pkg::MODE_SMOOTH);
    m0x     = smooth2 ? a2  : ai2;
    m0y     = smooth2 ? b2  : ai2;
    m1x     = smooth2 ? gl2 : ao2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_a[0] <= m0x * m0y;
      lane_a[1] <= m1x * (smooth2 ? b2 : ao2);
      lane_a[2] <= smooth2 ? (gr2 * a2) : bntc_pkg::PROD_W'(s2);
      lane_a[3] <= bntc_pkg::PROD_W'(s2);
      lane_b[0] <= smooth2 ? f12  : bntc_pkg::FAC_W'(po2);
      lane_b[1] <= smooth2 ? gfl2 : bntc_pkg::FAC_W'(pi2);
      lane_b[2] <= smooth2 ? gfr2 : bntc_pkg::FAC_W'(po2);
      lane_b[3] <= bntc_pkg::FAC_W'(pi2);
      front     <= '{kind: mode2, pi: pi2, po: po2, ci_neg: ci_neg2, co_neg: co_neg2,
                     lin_in: a2, lin_out: b2, side_in: side_in2, side_out: side_out2};
    end
  end

endmodule

@@ rtl/core/bntc_mul.sv @@
// ----------------------------------------------------------------------------
// Bezier node tangent calculator: pipelined multiplier
// Several lanes of A x B, one digit of B per stage, with a shared sideband.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bntc_mul #(
  parameter int LANES = 2,
  parameter int A_W   = 64,
  parameter int B_W   = 32,
  parameter int DIG_W = 8,
  parameter int SB_W  = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [LANES-1:0][A_W-1:0]         a,
  input  logic [LANES-1:0][B_W-1:0]         b,
  input  logic [SB_W-1:0]                   sb_in,
  output logic                              out_valid,
  output logic [LANES-1:0][A_W+B_W-1:0]     p,
  output logic [SB_W-1:0]                   sb_out
);

  localparam int NDIG = (B_W + DIG_W - 1) / DIG_W;
  localparam int BP_W = NDIG * DIG_W;
  localparam int X_W  = A_W + BP_W;
  localparam int P_W  = A_W + B_W;

  logic [LANES-1:0][X_W-1:0]  acc [NDIG];
  logic [LANES-1:0][A_W-1:0]  ar  [NDIG];
  logic [LANES-1:0][BP_W-1:0] br  [NDIG];
  logic [SB_W-1:0]            sbr [NDIG];
  logic                       vld [NDIG];

  for (genvar k = 0; k < NDIG; k++) begin : g_stage
    logic [LANES-1:0][A_W-1:0]       a_src;
    logic [LANES-1:0][BP_W-1:0]      b_src;
    logic [LANES-1:0][X_W-1:0]       acc_src;
    logic [LANES-1:0][A_W+DIG_W-1:0] pp;
    logic                            v_src;
    logic [SB_W-1:0]                 sb_src;

    if (k == 0) begin : g_first
      always_comb begin
        a_src  = a;
        v_src  = in_valid;
        sb_src = sb_in;
        for (int l = 0; l < LANES; l++) begin
          b_src[l]   = BP_W'(b[l]);
          acc_src[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        a_src   = ar[k-1];
        b_src   = br[k-1];
        acc_src = acc[k-1];
        v_src   = vld[k-1];
        sb_src  = sbr[k-1];
      end
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        pp[l] = a_src[l] * b_src[l][DIG_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          acc[k][l] <= acc_src[l] + (X_W'(pp[l]) << (k * DIG_W));
          br[k][l]  <= b_src[l] >> DIG_W;
        end
        ar[k]  <= a_src;
        sbr[k] <= sb_src;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      p[l] = acc[NDIG-1][l][P_W-1:0];
    end
    out_valid = vld[NDIG-1];
    sb_out    = sbr[NDIG-1];
  end

endmodule

@@ rtl/core/bntc_div.sv @@
// ----------------------------------------------------------------------------
// Bezier node tangent calculator: pipelined divider
// Restoring division, one quotient bit per stage, then rounding to nearest
// (ties away from zero), sign and saturation to the signed level range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bntc_div #(
  parameter int LANES = 2,
  parameter int SB_W  = 1
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       en,
  input  logic                                       in_valid,
  input  logic [LANES-1:0][bntc_pkg::NUM_W-1:0]      num,
  input  logic [LANES-1:0][bntc_pkg::DEN_W-1:0]      den,
  input  logic [LANES-1:0]                           neg,
  input  logic [SB_W-1:0]                            sb_in,
  output logic                                       out_valid,
  output logic [LANES-1:0][bntc_pkg::LVL_W-1:0]      q,
  output logic [SB_W-1:0]                            sb_out
);

  localparam int QW  = bntc_pkg::Q_W;
  localparam int DW  = bntc_pkg::DEN_W;
  localparam int NW  = bntc_pkg::NUM_W;
  localparam int LW  = bntc_pkg::LVL_W;

  logic [LANES-1:0][DW-1:0] rem  [QW+1];
  logic [LANES-1:0][DW-1:0] dr   [QW+1];
  logic [LANES-1:0][QW-1:0] low  [QW+1];
  logic [LANES-1:0][QW-1:0] quo  [QW+1];
  logic [LANES-1:0]         ngr  [QW+1];
  logic [LANES-1:0]         ovr  [QW+1];
  logic [SB_W-1:0]          sbr  [QW+1];
  logic                     vld  [QW+1];

  // ---- overflow check: a quotient of 2^QW or more always saturates ----
  logic [LANES-1:0] ov_c;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      ov_c[l] = DW'(num[l][NW-1:QW]) >= den[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        rem[0][l] <= ov_c[l] ? '0 : DW'(num[l][NW-1:QW]);
        low[0][l] <= num[l][QW-1:0];
        quo[0][l] <= '0;
      end
      dr[0]  <= den;
      ngr[0] <= neg;
      ovr[0] <= ov_c;
      sbr[0] <= sb_in;
    end
  end

  // ---- one quotient bit per stage ----
  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [LANES-1:0][DW:0]   r2;
    logic [LANES-1:0][DW+1:0] diff;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        r2[l]   = {rem[k-1][l], low[k-1][l][QW-1]};
        diff[l] = {1'b0, r2[l]} - {2'b00, dr[k-1][l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          rem[k][l] <= diff[l][DW+1] ? r2[l][DW-1:0] : diff[l][DW-1:0];
          quo[k][l] <= {quo[k-1][l][QW-2:0], !diff[l][DW+1]};
          low[k][l] <= {low[k-1][l][QW-2:0], 1'b0};
        end
        dr[k]  <= dr[k-1];
        ngr[k] <= ngr[k-1];
        ovr[k] <= ovr[k-1];
        sbr[k] <= sbr[k-1];
      end
    end
  end

  // ---- rounding ----
  logic                       vr;
  logic [LANES-1:0][QW:0]     qr;
  logic [LANES-1:0]           ngrr, ovrr;
  logic [SB_W-1:0]            sbrr;
  logic [LANES-1:0]           up_c;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      up_c[l] = {rem[QW][l], 1'b0} >= {1'b0, dr[QW][l]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else if (en) begin
      vr <= vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        qr[l] <= {1'b0, quo[QW][l]} + (QW+1)'(up_c[l]);
      end
      ngrr <= ngr[QW];
      ovrr <= ovr[QW];
      sbrr <= sbr[QW];
    end
  end

  // ---- saturation and sign ----
  logic [LANES-1:0][QW:0]   lim_c, mag_c;
  logic [LANES-1:0][LW-1:0] res_c;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lim_c[l] = ((QW+1)'(1) << (LW - 1)) - (QW+1)'(!ngrr[l]);
      mag_c[l] = (ovrr[l] || (qr[l] > lim_c[l])) ? lim_c[l] : qr[l];
      res_c[l] = ngrr[l] ? (LW'(0) - mag_c[l][LW-1:0]) : mag_c[l][LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q      <= res_c;
      sb_out <= sbrr;
    end
  end

endmodule

@@ rtl/core/bezier_node_tangent_calc.sv @@
// ----------------------------------------------------------------------------
// Bezier node tangent calculator
// Control point offsets and control levels of one automation node.
// ----------------------------------------------------------------------------
//
//  channel | dir | words
//  --------+-----+--------------------------------------------------------
//  s_*     | in  | one node: mode, neighbour flags, gaps, levels
//  m_*     | out | one result: control positions and control levels
//
// A new word is taken every cycle while the output is not stalled. Each word
// passes through the pipeline in this order: three front-end stages, the first
// wide multiplier (ceil(50 / MUL_DIGIT_W) stages), one combining stage, the
// second wide multiplier (ceil(31 / MUL_DIGIT_W) stages), the divider (one
// stage per quotient bit, 33 in all, plus three) and the output register.
// The divider's bit-per-stage chain makes up most of the pipeline stages.
// Reset is synchronous and clears only the valid bits. When the output
// word is not taken, every stage holds together and s_tready drops;
// bubbles in the pipeline are kept, nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bezier_node_tangent_calc_macros.svh"

module bezier_node_tangent_calc #(
  parameter int MUL_DIGIT_W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [31:0] left_gap, [63:32] right_gap, [95:64] prev_level,
  // [127:96] node_level, [159:128] next_level,
  // [191:160] in_ctrl_level_now, [223:192] out_ctrl_level_now
  input  logic [223:0] s_tdata,
  // [1:0] mode, [2] has_prev, [3] has_next
  input  logic [3:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] in_ctrl_pos, [62:32] out_ctrl_pos, [94:63] in_ctrl_level,
  // [126:95] out_ctrl_level, [127] zero
  output logic [127:0] m_tdata
);

  localparam int FRONT_W = $bits(bntc_pkg::front_t);
  localparam int MID_W   = $bits(bntc_pkg::mid_t);
  localparam int BACK_W  = $bits(bntc_pkg::back_t);

  // The whole pipeline moves together; it only stops while a finished
  // word sits in the output register and is not being taken.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---- front end ----
  logic                                                      fe_valid;
  logic [bntc_pkg::M1_LANES-1:0][bntc_pkg::PROD_W-1:0]       fe_a;
  logic [bntc_pkg::M1_LANES-1:0][bntc_pkg::FAC_W-1:0]        fe_b;
  bntc_pkg::front_t                                          fe_front;

  bntc_prep u_prep (
    .clk                (clk),
    .rst                (rst),
    .en                 (en),
    .in_valid           (s_tvalid),
    .mode               (bntc_pkg::mode_t'(s_tuser[1:0])),
    .has_prev           (s_tuser[2]),
    .has_next           (s_tuser[3]),
    .left_gap           (s_tdata[31:0]),
    .right_gap          (s_tdata[63:32]),
    .prev_level         (s_tdata[95:64]),
    .node_level         (s_tdata[127:96]),
    .next_level         (s_tdata[159:128]),
    .in_ctrl_level_now  (s_tdata[191:160]),
    .out_ctrl_level_now (s_tdata[223:192]),
    .out_valid          (fe_valid),
    .lane_a             (fe_a),
    .lane_b             (fe_b),
    .front              (fe_front)
  );

  // ---- first wide multiplier ----
  // Smooth: core term and the two halves of the weight sum.
  // Tied free: both squared levels and both divisors.
  logic                                                      m1_valid;
  logic [bntc_pkg::M1_LANES-1:0][bntc_pkg::WIDE_W-1:0]       m1_p;
  logic [FRONT_W-1:0]                                        m1_sb;
  bntc_pkg::front_t                                          f;

  bntc_mul #(
    .LANES (bntc_pkg::M1_LANES),
    .A_W   (bntc_pkg::PROD_W),
    .B_W   (bntc_pkg::FAC_W),
    .DIG_W (MUL_DIGIT_W),
    .SB_W  (FRONT_W)
  ) u_mul1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fe_valid),
    .a         (fe_a),
    .b         (fe_b),
    .sb_in     (fe_front),
    .out_valid (m1_valid),
    .p         (m1_p),
    .sb_out    (m1_sb)
  );

  assign f = bntc_pkg::front_t'(m1_sb);

  // ---- combining stage ----
  // Sets up dividend factors and divisors for whichever mode the word has.
  logic [bntc_pkg::WIDE_W:0]    d12, d21;
  logic [bntc_pkg::WIDE_W-1:0]  tied_num;
  logic                         tied_neg;
  logic [bntc_pkg::WIDE_W-1:0]  x0_next, x1_next;
  logic [bntc_pkg::POS_W-1:0]   y0_next, y1_next;
  logic [bntc_pkg::DEN_W-1:0]   den_in_next, den_out_next;
  bntc_pkg::side_t              side_in_next, side_out_next;

  always_comb begin
    d12 = {1'b0, m1_p[0]} - {1'b0, m1_p[1]};
    d21 = {1'b0, m1_p[1]} - {1'b0, m1_p[0]};
    if (f.ci_neg != f.co_neg) begin
      tied_num = m1_p[0] + m1_p[1];
      tied_neg = f.ci_neg;
    end else if (!d12[bntc_pkg::WIDE_W]) begin
      tied_num = d12[bntc_pkg::WIDE_W-1:0];
      tied_neg = f.ci_neg;
    end else begin
      tied_num = d21[bntc_pkg::WIDE_W-1:0];
      tied_neg = !f.ci_neg;
    end

    side_in_next  = f.side_in;
    side_out_next = f.side_out;
    x0_next       = '0;
    x1_next       = '0;
    y0_next       = '0;
    y1_next       = '0;
    den_in_next   = bntc_pkg::DEN_W'(1);
    den_out_next  = bntc_pkg::DEN_W'(1);

    unique case (f.kind)
      bntc_pkg::MODE_SMOOTH: begin
        x0_next      = m1_p[0];
        x1_next      = m1_p[0];
        y0_next      = f.pi;
        y1_next      = f.po;
        den_in_next  = m1_p[1] + m1_p[2];
        den_out_next = m1_p[1] + m1_p[2];
      end
      bntc_pkg::MODE_LINEAR: begin
        x0_next      = bntc_pkg::WIDE_W'(f.lin_in);
        x1_next      = bntc_pkg::WIDE_W'(f.lin_out);
        y0_next      = bntc_pkg::POS_W'(1);
        y1_next      = bntc_pkg::POS_W'(1);
        den_in_next  = bntc_pkg::DEN_W'(bntc_pkg::THIRD_DIV);
        den_out_next = bntc_pkg::DEN_W'(bntc_pkg::THIRD_DIV);
      end
      bntc_pkg::MODE_TIED: begin
        x0_next           = tied_num;
        x1_next           = tied_num;
        y0_next           = bntc_pkg::POS_W'(1);
        y1_next           = bntc_pkg::POS_W'(1);
        den_in_next       = m1_p[2];
        den_out_next      = m1_p[3];
        side_in_next.neg  = tied_neg;
        side_out_next.neg = !tied_neg;
      end
      bntc_pkg::MODE_FREE: begin
        x0_next = '0;
      end
      default: begin
        x0_next = '0;
      end
    endcase
  end

  logic                                                      c_valid;
  logic [bntc_pkg::M2_LANES-1:0][bntc_pkg::WIDE_W-1:0]       c_x;
  logic [bntc_pkg::M2_LANES-1:0][bntc_pkg::POS_W-1:0]        c_y;
  bntc_pkg::mid_t                                            c_mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_x   <= {x1_next, x0_next};
      c_y   <= {y1_next, y0_next};
      c_mid <= '{pi: f.pi, po: f.po, side_in: side_in_next, side_out: side_out_next,
                 den_in: den_in_next, den_out: den_out_next};
    end
  end

  // ---- second wide multiplier: dividends ----
  logic                                                      m2_valid;
  logic [bntc_pkg::M2_LANES-1:0][bntc_pkg::NUM_W-1:0]        m2_p;
  logic [MID_W-1:0]                                          m2_sb;
  bntc_pkg::mid_t                                            mid;
  bntc_pkg::back_t                                           mid_back;

  bntc_mul #(
    .LANES (bntc_pkg::M2_LANES),
    .A_W   (bntc_pkg::WIDE_W),
    .B_W   (bntc_pkg::POS_W),
    .DIG_W (MUL_DIGIT_W),
    .SB_W  (MID_W)
  ) u_mul2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_valid),
    .a         (c_x),
    .b         (c_y),
    .sb_in     (c_mid),
    .out_valid (m2_valid),
    .p         (m2_p),
    .sb_out    (m2_sb)
  );

  assign mid      = bntc_pkg::mid_t'(m2_sb);
  assign mid_back = '{pi: mid.pi, po: mid.po, side_in: mid.side_in, side_out: mid.side_out};

  // ---- divider ----
  logic                                                      dv_valid;
  logic [bntc_pkg::M2_LANES-1:0][bntc_pkg::LVL_W-1:0]        dv_q;
  logic [BACK_W-1:0]                                         dv_sb;
  bntc_pkg::back_t                                           bk;

  bntc_div #(
    .LANES (bntc_pkg::M2_LANES),
    .SB_W  (BACK_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m2_valid),
    .num       (m2_p),
    .den       ({mid.den_out, mid.den_in}),
    .neg       ({mid.side_out.neg, mid.side_in.neg}),
    .sb_in     (mid_back),
    .out_valid (dv_valid),
    .q         (dv_q),
    .sb_out    (dv_sb)
  );

  assign bk = bntc_pkg::back_t'(dv_sb);

  // ---- output register ----
  // Sides that need no division take their pass-through level here.
  logic [bntc_pkg::LVL_W-1:0] in_pos_c, in_lvl_c, out_lvl_c;

  always_comb begin
    in_pos_c  = bntc_pkg::LVL_W'(0) - bntc_pkg::LVL_W'(bk.pi);
    in_lvl_c  = bk.side_in.bypass  ? bk.side_in.value  : dv_q[0];
    out_lvl_c = bk.side_out.bypass ? bk.side_out.value : dv_q[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {1'b0, out_lvl_c, in_lvl_c, bk.po, in_pos_c};
    end
  end

  // ---- checks ----
  `BNTC_ASSERT(a_out_pos_range, m_tvalid |-> (m_tdata[62:32] <= 31'd1431655765), "out_ctrl_pos above a third of the largest gap")
  `BNTC_ASSERT(a_in_pos_sign, m_tvalid |-> (m_tdata[31] || (m_tdata[31:0] == 32'd0)), "in_ctrl_pos positive")
  `BNTC_ASSERT(a_stall_blocks_input, (m_tvalid && !m_tready) |-> !s_tready, "input taken while output stalled")
  `BNTC_ASSERT_ALWAYS(a_empty_after_reset, rst |=> !m_tvalid, "output word present straight after reset")

endmodule
